// ===== design/sbac_pkg.sv =====
`default_nettype none

package sbac_pkg;

  typedef logic [15:0] word_t;

  // Result of one ALU evaluation.
  typedef struct packed {
    word_t value;
    logic  bad;
  } alu_out_t;

  // Compute instruction layout.
  localparam logic [2:0] OPC_COMPUTE = 3'b111;

  // Comp field codes (bits 11..6).
  localparam logic [5:0] COMP_CONST_0 = 6'h2A;
  localparam logic [5:0] COMP_ONE     = 6'h3F;
  localparam logic [5:0] COMP_NEG_ONE = 6'h3A;
  localparam logic [5:0] COMP_D       = 6'h0C;
  localparam logic [5:0] COMP_NOT_D   = 6'h0D;
  localparam logic [5:0] COMP_NEG_D   = 6'h0F;
  localparam logic [5:0] COMP_D_INC   = 6'h1F;
  localparam logic [5:0] COMP_D_DEC   = 6'h0E;
  localparam logic [5:0] COMP_Y       = 6'h30;
  localparam logic [5:0] COMP_NOT_Y   = 6'h31;
  localparam logic [5:0] COMP_NEG_Y   = 6'h33;
  localparam logic [5:0] COMP_Y_INC   = 6'h37;
  localparam logic [5:0] COMP_Y_DEC   = 6'h32;
  localparam logic [5:0] COMP_D_ADD_Y = 6'h02;
  localparam logic [5:0] COMP_D_SUB_Y = 6'h13;
  localparam logic [5:0] COMP_Y_SUB_D = 6'h07;
  localparam logic [5:0] COMP_D_AND_Y = 6'h00;
  localparam logic [5:0] COMP_D_OR_Y  = 6'h15;

endpackage

`default_nettype wire

// ===== design/sbac_alu.sv =====
`default_nettype none

module sbac_alu
  import sbac_pkg::*;
(
  input  wire logic [5:0] comp,
  input  wire logic       a_bit,
  input  wire word_t      x,
  input  wire word_t      y,
  output alu_out_t        res
);

  logic d_only;

  always_comb begin
    res.value = '0;
    res.bad   = 1'b0;
    d_only    = 1'b0;
    case (comp)
      COMP_CONST_0: begin
        d_only = 1'b1;
      end
      COMP_ONE: begin
        res.value = 16'd1;
        d_only = 1'b1;
      end
      COMP_NEG_ONE: begin
        res.value = 16'hFFFF;
        d_only = 1'b1;
      end
      COMP_D: begin
        res.value = x;
        d_only = 1'b1;
      end
      COMP_NOT_D: begin
        res.value = ~x;
        d_only = 1'b1;
      end
      COMP_NEG_D: begin
        res.value = 16'd0 - x;
        d_only = 1'b1;
      end
      COMP_D_INC: begin
        res.value = x + 16'd1;
        d_only = 1'b1;
      end
      COMP_D_DEC: begin
        res.value = x - 16'd1;
        d_only = 1'b1;
      end
      COMP_Y:       res.value = y;
      COMP_NOT_Y:   res.value = ~y;
      COMP_NEG_Y:   res.value = 16'd0 - y;
      COMP_Y_INC:   res.value = y + 16'd1;
      COMP_Y_DEC:   res.value = y - 16'd1;
      COMP_D_ADD_Y: res.value = x + y;
      COMP_D_SUB_Y: res.value = x - y;
      COMP_Y_SUB_D: res.value = y - x;
      COMP_D_AND_Y: res.value = x & y;
      COMP_D_OR_Y:  res.value = x | y;
      default: begin
        res.bad = 1'b1;
      end
    endcase
    // Constant and D-only functions exist only with the A operand selected.
    if (d_only && a_bit) begin
      res.value = '0;
      res.bad   = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/sbac_ram.sv =====
`default_nettype none

module sbac_ram
  import sbac_pkg::*;
#(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire word_t         wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output word_t              rd_data,
  output logic               busy
);

  word_t         mem [DEPTH];
  word_t         rd_data_r;
  logic          busy_r;
  logic [AW-1:0] clr_addr_r;

  // After reset the array is swept to zero, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && rst_n) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

`default_nettype wire

// ===== design/sixteen_bit_accumulator_cpu_step.sv =====
// Executes one word of the 16-bit teaching CPU per accepted input word and returns one result
// word with the new PC, A and D, the ALU value, a store flag and a bad-comp flag. D, A, PC and a
// RAM_DEPTH-entry data RAM live inside; after reset the RAM is swept to zero, during which
// in_ready stays low. Each instruction passes through an input register and the decode/ALU
// logic into the output register, so words that do not read RAM (load-A words and compute
// words with a=0) sustain one per cycle while the output is not stalled. A compute word with
// a=1 reads RAM[A] from the synchronous RAM, whose registered read port tracks the current A;
// when the previous word changed A or stored to RAM, that word waits for a fresh read.
`default_nettype none

module sixteen_bit_accumulator_cpu_step
  import sbac_pkg::*;
#(
  parameter int RAM_DEPTH = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_instruction,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_next_pc,
  output logic [15:0]      out_a_value,
  output logic [15:0]      out_d_value,
  output logic [15:0]      out_alu_value,
  output logic             out_memory_written,
  output logic             out_bad_comp
);

  localparam int          AW      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam logic [16:0] DEPTH_W = 17'(RAM_DEPTH);

  // Input register.
  word_t    instr_r;
  logic     ivalid_r;

  // Architectural state.
  word_t    a_r, a_nxt;
  word_t    d_r, d_nxt;
  word_t    pc_r, pc_nxt;

  // The RAM read port always follows A; this flag says its data matches the current A and RAM.
  logic     rd_valid_r;
  word_t    rd_data;
  logic     ram_busy;

  // Output register.
  logic     ovalid_r;
  word_t    o_pc_r, o_a_r, o_d_r, o_alu_r;
  logic     o_wr_r, o_bad_r;

  // Decode.
  logic       is_comp;
  logic       a_bit;
  logic [5:0] comp;
  logic [2:0] dest;
  logic [2:0] jmp;
  logic       in_range;
  logic       need_mem;
  logic       exec;
  word_t      y_val;
  word_t      result;
  logic       bad;
  logic       wr_mem;
  logic       take;
  logic       neg, zero, pos;
  alu_out_t   alu_res;

  assign is_comp  = (instr_r[15:13] == OPC_COMPUTE);
  assign a_bit    = instr_r[12];
  assign comp     = instr_r[11:6];
  assign dest     = instr_r[5:3];
  assign jmp      = instr_r[2:0];
  assign in_range = ({1'b0, a_r} < DEPTH_W);
  assign need_mem = is_comp && a_bit;

  // An item executes when it sits in the input register, the output register can take the
  // result and, for a memory operand, the read data is current.
  assign exec     = ivalid_r && (!ovalid_r || out_ready) && (!need_mem || rd_valid_r);
  assign in_ready = rst_n && !ram_busy && (!ivalid_r || exec);

  // Addresses at or above the RAM depth read as zero.
  assign y_val = a_bit ? (in_range ? rd_data : 16'd0) : a_r;

  sbac_alu u_alu (
    .comp  (comp),
    .a_bit (a_bit),
    .x     (d_r),
    .y     (y_val),
    .res   (alu_res)
  );

  always_comb begin
    result = is_comp ? alu_res.value : 16'd0;
    bad    = is_comp && alu_res.bad;
    wr_mem = is_comp && dest[0] && in_range;
    d_nxt  = (is_comp && dest[1]) ? result : d_r;
    if (!is_comp) begin
      a_nxt = instr_r;
    end else if (dest[2]) begin
      a_nxt = result;
    end else begin
      a_nxt = a_r;
    end
    neg  = result[15];
    zero = (result == 16'd0);
    pos  = !neg && !zero;
    take = is_comp && ((jmp[2] && neg) || (jmp[1] && zero) || (jmp[0] && pos));
    // A taken jump goes to the A held before this word.
    pc_nxt = take ? a_r : (pc_r + 16'd1);
  end

  sbac_ram #(
    .DEPTH (RAM_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (exec && wr_mem),
    .wr_addr (a_r[AW-1:0]),
    .wr_data (result),
    .rd_addr (a_r[AW-1:0]),
    .rd_data (rd_data),
    .busy    (ram_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      ivalid_r <= 1'b1;
    end else if (exec) begin
      ivalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      instr_r <= in_instruction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      d_r  <= '0;
      pc_r <= '0;
    end else if (exec) begin
      a_r  <= a_nxt;
      d_r  <= d_nxt;
      pc_r <= pc_nxt;
    end
  end

  // The read issued at an edge that changes A or writes RAM returns stale data, so the flag
  // drops there and comes back with the following read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (exec && (a_nxt != a_r || wr_mem)) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= !ram_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (exec) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      o_pc_r  <= pc_nxt;
      o_a_r   <= a_nxt;
      o_d_r   <= d_nxt;
      o_alu_r <= result;
      o_wr_r  <= wr_mem;
      o_bad_r <= bad;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_next_pc        = o_pc_r;
  assign out_a_value        = o_a_r;
  assign out_d_value        = o_d_r;
  assign out_alu_value      = o_alu_r;
  assign out_memory_written = o_wr_r;
  assign out_bad_comp       = o_bad_r;

endmodule

`default_nettype wire

// ===== design/sbac_checker.sv =====
`default_nettype none

module sbac_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [15:0] in_instruction,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_next_pc,
  input wire logic [15:0] out_a_value,
  input wire logic [15:0] out_d_value,
  input wire logic [15:0] out_alu_value,
  input wire logic        out_memory_written,
  input wire logic        out_bad_comp
);

  logic [15:0] last_pc_r;
  logic [15:0] last_a_r;
  logic        have_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_pc_r <= out_next_pc;
      last_a_r  <= out_a_value;
    end
  end

  // A waiting instruction word keeps its contents until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_instruction))
    else $error("instruction word changed while waiting");

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) && $stable(out_a_value)
      && $stable(out_d_value) && $stable(out_alu_value) && $stable(out_memory_written)
      && $stable(out_bad_comp))
    else $error("result word changed while stalled");

  // A bad comp code always produces a zero ALU value.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_comp |-> out_alu_value == 16'd0)
    else $error("bad comp code with nonzero ALU value");

  // The PC either advances by one or jumps to the A left by the previous word.
  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && have_r |-> out_next_pc == last_pc_r + 16'd1 || out_next_pc == last_a_r)
    else $error("next PC neither sequential nor a jump to old A");

  // The first word after reset starts from PC zero and A zero.
  a_pc_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !have_r |-> out_next_pc == 16'd1 || out_next_pc == 16'd0)
    else $error("first next PC not derived from reset state");

endmodule

bind sixteen_bit_accumulator_cpu_step sbac_checker u_sbac_checker (.*);

`default_nettype wire

// ===== dv/sixteen_bit_accumulator_cpu_step_tb.sv =====
`default_nettype none

module sixteen_bit_accumulator_cpu_step_tb
  import sbac_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAM_DEPTH = 32768;

  // The limit covers the RAM clear after reset and, for each word, its own handling plus
  // the longest idle stretch on each side. The limit below is several times that worst case.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned MAX_IDLE     = 14;
  localparam int unsigned REPORT_LIMIT = 10;

  // Destination bits of a compute word: A, D, M from high to low.
  localparam logic [2:0] DEST_NONE = 3'b000;
  localparam logic [2:0] DEST_M    = 3'b001;
  localparam logic [2:0] DEST_D    = 3'b010;
  localparam logic [2:0] DEST_A    = 3'b100;

  // Jump conditions: lt, eq, gt from high to low.
  localparam logic [2:0] JUMP_NONE   = 3'b000;
  localparam logic [2:0] JUMP_EQ     = 3'b010;
  localparam logic [2:0] JUMP_ALWAYS = 3'b111;

  // A comp code that is not one of the defined functions.
  localparam logic [5:0] COMP_UNDEF = 6'h3B;

  typedef struct packed {
    word_t next_pc;
    word_t a_value;
    word_t d_value;
    word_t alu_value;
    logic  memory_written;
    logic  bad_comp;
  } cpu_result_t;

  // All inputs of the block hold known values from time zero.
  logic  clk            = 1'b0;
  logic  rst_n          = 1'b0;
  logic  in_valid       = 1'b0;
  word_t in_instruction = '0;
  logic  out_ready      = 1'b0;

  logic  in_ready;
  logic  out_valid;
  word_t out_next_pc;
  word_t out_a_value;
  word_t out_d_value;
  word_t out_alu_value;
  logic  out_memory_written;
  logic  out_bad_comp;

  sixteen_bit_accumulator_cpu_step #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instruction    (in_instruction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_pc       (out_next_pc),
    .out_a_value       (out_a_value),
    .out_d_value       (out_d_value),
    .out_alu_value     (out_alu_value),
    .out_memory_written(out_memory_written),
    .out_bad_comp      (out_bad_comp)
  );

  always #10 clk = ~clk;

  // Program words still to be sent, and the results that accepted words must produce.
  word_t       program_words[$];
  cpu_result_t pending_results[$];

  // The CPU state as the testbench sees it: D, A, PC and the data RAM.
  word_t d_model;
  word_t a_model;
  word_t pc_model;
  word_t ram_model[RAM_DEPTH];

  int unsigned failures    = 0;
  int unsigned cycle_count = 0;

  // Idle bookkeeping for both sides. A quiet flag suppresses idling for a stretch of
  // words so that back-to-back traffic is exercised as well.
  int unsigned send_gap    = 0;
  int unsigned recv_stall  = 0;
  bit          send_quiet  = 1'b0;
  bit          recv_quiet  = 1'b0;

  // The 18 defined comp codes. Indices 8 and up use the second operand, so only those
  // are defined with the a bit set.
  function automatic logic [5:0] defined_comp(input int unsigned idx);
    case (idx)
      0:       return COMP_CONST_0;
      1:       return COMP_ONE;
      2:       return COMP_NEG_ONE;
      3:       return COMP_D;
      4:       return COMP_NOT_D;
      5:       return COMP_NEG_D;
      6:       return COMP_D_INC;
      7:       return COMP_D_DEC;
      8:       return COMP_Y;
      9:       return COMP_NOT_Y;
      10:      return COMP_NEG_Y;
      11:      return COMP_Y_INC;
      12:      return COMP_Y_DEC;
      13:      return COMP_D_ADD_Y;
      14:      return COMP_D_SUB_Y;
      15:      return COMP_Y_SUB_D;
      16:      return COMP_D_AND_Y;
      default: return COMP_D_OR_Y;
    endcase
  endfunction

  function automatic word_t compute_word(input logic a_bit, input logic [5:0] comp,
                                         input logic [2:0] dest, input logic [2:0] jmp);
    return {OPC_COMPUTE, a_bit, comp, dest, jmp};
  endfunction

  // ALU of the CPU. x is D, y is A or RAM[A] depending on the a bit. Codes that ignore y
  // are undefined when the a bit is set; an undefined code yields zero.
  function automatic alu_out_t alu_compute(input logic [5:0] comp, input logic a_bit,
                                           input word_t x, input word_t y);
    alu_out_t r;
    logic     uses_y;
    r.value = '0;
    r.bad   = 1'b0;
    uses_y  = 1'b1;
    case (comp)
      COMP_CONST_0: begin r.value = 16'h0000; uses_y = 1'b0; end
      COMP_ONE:     begin r.value = 16'h0001; uses_y = 1'b0; end
      COMP_NEG_ONE: begin r.value = 16'hFFFF; uses_y = 1'b0; end
      COMP_D:       begin r.value = x;        uses_y = 1'b0; end
      COMP_NOT_D:   begin r.value = ~x;       uses_y = 1'b0; end
      COMP_NEG_D:   begin r.value = -x;       uses_y = 1'b0; end
      COMP_D_INC:   begin r.value = x + 1'b1; uses_y = 1'b0; end
      COMP_D_DEC:   begin r.value = x - 1'b1; uses_y = 1'b0; end
      COMP_Y:       r.value = y;
      COMP_NOT_Y:   r.value = ~y;
      COMP_NEG_Y:   r.value = -y;
      COMP_Y_INC:   r.value = y + 1'b1;
      COMP_Y_DEC:   r.value = y - 1'b1;
      COMP_D_ADD_Y: r.value = x + y;
      COMP_D_SUB_Y: r.value = x - y;
      COMP_Y_SUB_D: r.value = y - x;
      COMP_D_AND_Y: r.value = x & y;
      COMP_D_OR_Y:  r.value = x | y;
      default:      r.bad = 1'b1;
    endcase
    if (!uses_y && a_bit) begin
      r.bad = 1'b1;
    end
    if (r.bad) begin
      r.value = '0;
    end
    return r;
  endfunction

  // Executes one instruction word on the model state and returns the result word the
  // block must produce for it. The RAM operand, the store and the jump target all use
  // the value A held before this word.
  function automatic cpu_result_t execute_word(input word_t ins);
    cpu_result_t r;
    alu_out_t    alu;
    word_t       old_a;
    word_t       mem_val;
    logic        in_ram;
    logic        neg;
    logic        zero;
    logic        take;
    old_a  = a_model;
    in_ram = int'(old_a) < RAM_DEPTH;
    r      = '0;
    if (ins[15:13] == OPC_COMPUTE) begin
      mem_val = '0;
      if (in_ram) begin
        mem_val = ram_model[old_a];
      end
      alu = alu_compute(ins[11:6], ins[12], d_model, ins[12] ? mem_val : old_a);
      r.alu_value = alu.value;
      r.bad_comp  = alu.bad;
      // A store beyond the end of the RAM is dropped and not flagged.
      if (ins[3] && in_ram) begin
        ram_model[old_a] = alu.value;
        r.memory_written = 1'b1;
      end
      if (ins[4]) begin
        d_model = alu.value;
      end
      if (ins[5]) begin
        a_model = alu.value;
      end
      neg  = alu.value[15];
      zero = alu.value == '0;
      take = (ins[2] && neg) || (ins[1] && zero) || (ins[0] && !neg && !zero);
      pc_model = take ? old_a : pc_model + 1'b1;
    end else begin
      a_model  = ins;
      pc_model = pc_model + 1'b1;
    end
    r.next_pc = pc_model;
    r.a_value = a_model;
    r.d_value = d_model;
    return r;
  endfunction

  function automatic int unsigned draw_idle(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // An address for a load A word: mostly a handful of low entries, so that stores are
  // read back often, with some words anywhere in the RAM, near its top, or beyond it.
  function automatic word_t random_address();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      return word_t'($urandom_range(0, 15));
    end else if (pick < 8) begin
      return word_t'($urandom_range(0, 16'h7FFF));
    end else if (pick < 9) begin
      return word_t'($urandom_range(16'h8000, 16'hDFFF));
    end
    return word_t'($urandom_range(16'h7FF0, 16'h7FFF));
  endfunction

  task automatic check_field(input string name, input word_t got, input word_t want);
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endtask

  // Driver. Whenever the input slot is free, either the idle gap for the next word is
  // counted down or the next program word is presented. A presented word stays put
  // until the block takes it, and the model executes it at that same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(execute_word(in_instruction));
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (program_words.size() != 0) begin
          in_valid       <= 1'b1;
          in_instruction <= program_words.pop_front();
          send_gap       <= draw_idle(send_quiet);
          if ($urandom_range(0, 29) == 0) begin
            send_quiet <= !send_quiet;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result word is compared with the oldest pending result. After each
  // accepted word, ready drops for a random number of cycles; a zero draw keeps it high.
  always @(posedge clk) begin
    cpu_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("result word with nothing pending: pc %h a %h d %h alu %h",
                     out_next_pc, out_a_value, out_d_value, out_alu_value);
          end
        end else begin
          want = pending_results.pop_front();
          check_field("next_pc", out_next_pc, want.next_pc);
          check_field("a_value", out_a_value, want.a_value);
          check_field("d_value", out_d_value, want.d_value);
          check_field("alu_value", out_alu_value, want.alu_value);
          check_field("memory_written", word_t'(out_memory_written),
                      word_t'(want.memory_written));
          check_field("bad_comp", word_t'(out_bad_comp), word_t'(want.bad_comp));
        end
        recv_stall = draw_idle(recv_quiet);
        if ($urandom_range(0, 29) == 0) begin
          recv_quiet <= !recv_quiet;
        end
        if (recv_stall != 0) begin
          out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (recv_stall <= 1) begin
          out_ready <= 1'b1;
        end
        if (recv_stall != 0) begin
          recv_stall = recv_stall - 1;
        end
      end
    end
  end

  // Watchdog for a block that stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sixteen_bit_accumulator_cpu_step] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    logic        a_bit;
    d_model  = '0;
    a_model  = '0;
    pc_model = '0;
    for (n = 0; n < RAM_DEPTH; n++) begin
      ram_model[n] = '0;
    end

    // Directed program. It starts with a store to RAM[5] that the very next word reads
    // back, then a taken jump on zero, then walks all 18 functions with A as the second
    // operand, varying dest and jump as it goes.
    program_words.push_back(16'h0005);
    program_words.push_back(compute_word(1'b0, COMP_NEG_ONE, DEST_M, JUMP_NONE));
    program_words.push_back(compute_word(1'b1, COMP_Y, DEST_D, JUMP_NONE));
    program_words.push_back(compute_word(1'b0, COMP_CONST_0, DEST_NONE, JUMP_EQ));
    for (n = 0; n < 18; n++) begin
      program_words.push_back(compute_word(1'b0, defined_comp(n), 3'(n % 8),
                                           3'((n * 3) % 8)));
    end
    // The highest load A value lies beyond the RAM: the store there is dropped and the
    // read returns zero.
    program_words.push_back(16'hDFFF);
    program_words.push_back(compute_word(1'b0, COMP_D, DEST_M, JUMP_ALWAYS));
    program_words.push_back(compute_word(1'b1, COMP_Y, DEST_D, JUMP_NONE));
    // The last RAM entry, then the all-ones word: a constant code with the a bit set is
    // undefined, and dest and jump still act on its zero result.
    program_words.push_back(16'h7FFF);
    program_words.push_back(16'hFFFF);
    program_words.push_back(compute_word(1'b0, COMP_UNDEF, DEST_D | DEST_A, JUMP_EQ));

    // Random program: mostly load A words and defined compute words, with raw words
    // mixed in that bring undefined codes and every bit pattern.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        program_words.push_back(random_address());
      end else if (pick < 88) begin
        a_bit = 1'($urandom_range(0, 1));
        program_words.push_back(compute_word(a_bit,
                                             defined_comp(a_bit ? $urandom_range(8, 17)
                                                                : $urandom_range(0, 17)),
                                             3'($urandom_range(0, 7)),
                                             3'($urandom_range(0, 7))));
      end else begin
        program_words.push_back(word_t'($urandom_range(0, 16'hFFFF)));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word was taken and every result has come back, then let the block run
    // on through a drain period to show any stray result.
    do begin
      @(posedge clk);
    end while (program_words.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && pending_results.size() == 0) begin
      $display("[sixteen_bit_accumulator_cpu_step] OK");
    end else begin
      $display("[sixteen_bit_accumulator_cpu_step] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sixteen_bit_accumulator_cpu_step.f =====
design/sbac_pkg.sv
design/sbac_alu.sv
design/sbac_ram.sv
design/sixteen_bit_accumulator_cpu_step.sv
design/sbac_checker.sv
dv/sixteen_bit_accumulator_cpu_step_tb.sv
